FILE: src/tia_pkg.sv
// ----------------------------------------------------------------------------
// tia_pkg
// Shared types, angle constants and the arctangent table generator for the
// table interpolated atan2 block.
// ----------------------------------------------------------------------------
package tia_pkg;

  // default configuration
  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_SAMPLE_WIDTH  = 16;

  // angle format: signed q3.13 radians
  localparam int ANGLE_W   = 16;
  // ratio format: 16 fraction bits, one integer bit (ratio of one is legal)
  localparam int FRAC_BITS = 16;
  localparam int RATIO_W   = FRAC_BITS + 1;

  localparam logic signed [ANGLE_W-1:0] ANG_PI         = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI    = 16'sd12868;
  localparam logic signed [ANGLE_W-1:0] ANG_QUARTER_PI = 16'sd6434;

  // per-request side information that travels with the divider and table path
  typedef struct packed {
    logic                      special;    // y zero or x zero
    logic signed [ANGLE_W-1:0] spec_angle; // angle for the special cases
    logic                      swap;       // |x| <= |y|: use pi/2 minus table angle
    logic                      x_pos;      // x > 0
    logic                      y_pos;      // y > 0
  } tia_tag_t;

  // elaboration-time generator for the table of atan(i/n)
  localparam int CORDIC_STEPS = 30;

  localparam longint CORDIC_ANGLES [CORDIC_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2
  };

  // vectoring cordic, angle accumulated in q2.30, rounded half up to q3.13
  function automatic logic [ANGLE_W-1:0] table_atan(input int num, input int den);
    longint      cx;
    longint      cy;
    longint      z;
    longint      sx;
    longint      sy;
    logic [ANGLE_W-1:0] res;
    cx = longint'(den) <<< 30;
    cy = longint'(num) <<< 30;
    z  = 0;
    if (num == 0) begin
      res = '0;
    end else begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        sx = cx >>> k;
        sy = cy >>> k;
        if (cy > 0) begin
          cx = cx + sy;
          cy = cy - sx;
          z  = z + CORDIC_ANGLES[k];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          z  = z - CORDIC_ANGLES[k];
        end
      end
      if (z < 0) begin
        z = 0;
      end
      res = ANGLE_W'((z + 64'sd65536) >>> 17);
    end
    return res;
  endfunction

endpackage

FILE: src/tia_div.sv
// ----------------------------------------------------------------------------
// tia_div
// Pipelined restoring divider: floor(small * 2^16 / large) for
// small <= large, one quotient bit per stage, side information carried along.
// ----------------------------------------------------------------------------
module tia_div #(
  parameter int SAMPLE_WIDTH = tia_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [SAMPLE_WIDTH-1:0]           in_small,
  input  logic [SAMPLE_WIDTH-1:0]           in_large,
  input  tia_pkg::tia_tag_t                 in_tag,
  output logic                              out_valid,
  output logic [tia_pkg::RATIO_W-1:0]       out_ratio,
  output tia_pkg::tia_tag_t                 out_tag
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int QW     = tia_pkg::RATIO_W;
  localparam int STAGES = QW;

  logic                    valid_r [STAGES];
  logic [W-1:0]            rem_r   [STAGES];
  logic [W-1:0]            large_r [STAGES];
  logic [QW-1:0]           quo_r   [STAGES];
  tia_pkg::tia_tag_t       tag_r   [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                  valid_in;
    logic [W-1:0]          rem_in;
    logic [W-1:0]          large_in;
    logic [QW-1:0]         quo_in;
    tia_pkg::tia_tag_t     tag_in;
    logic [W:0]            trial;
    logic [W:0]            diff;
    logic                  fits;
    logic [W-1:0]          rem_nxt;

    // stage inputs: first stage takes the request, later ones the previous stage
    if (i == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = in_small;
      assign large_in = in_large;
      assign quo_in   = '0;
      assign tag_in   = in_tag;
      // integer bit: remainder starts as the dividend itself
      assign trial    = {1'b0, rem_in};
    end else begin : g_next
      assign valid_in = valid_r[i-1];
      assign rem_in   = rem_r[i-1];
      assign large_in = large_r[i-1];
      assign quo_in   = quo_r[i-1];
      assign tag_in   = tag_r[i-1];
      // fraction bits: shift in a zero
      assign trial    = {rem_in, 1'b0};
    end

    // compare and subtract
    assign diff    = trial - {1'b0, large_in};
    assign fits    = (trial >= {1'b0, large_in});
    assign rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]   <= rem_nxt;
      large_r[i] <= large_in;
      quo_r[i]   <= {quo_in[QW-2:0], fits};
      tag_r[i]   <= tag_in;
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_ratio = quo_r[STAGES-1];
  assign out_tag   = tag_r[STAGES-1];

  // remainder stays below the divisor for every real division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[STAGES-1] && !tag_r[STAGES-1].special) |->
      (rem_r[STAGES-1] < large_r[STAGES-1]))
    else $error("tia_div: remainder not below divisor");

  // ratio never exceeds one
  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[STAGES-1] && !tag_r[STAGES-1].special) |->
      (quo_r[STAGES-1] <= QW'(1 << tia_pkg::FRAC_BITS)))
    else $error("tia_div: ratio above one");

endmodule

FILE: src/tia_interp.sv
// ----------------------------------------------------------------------------
// tia_interp
// Scales the ratio into a table index and fraction, reads two neighboring
// entries of the arctangent rom and interpolates between them.
// ----------------------------------------------------------------------------
module tia_interp #(
  parameter int TABLE_ENTRIES = tia_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic [tia_pkg::RATIO_W-1:0]            in_ratio,
  input  tia_pkg::tia_tag_t                      in_tag,
  output logic                                   out_valid,
  output logic signed [tia_pkg::ANGLE_W-1:0]     out_oct,
  output tia_pkg::tia_tag_t                      out_tag
);

  localparam int FB = tia_pkg::FRAC_BITS;
  localparam int AWD = tia_pkg::ANGLE_W;
  localparam int AW = $clog2(TABLE_ENTRIES + 1);
  localparam int PW = FB + AW;

  typedef logic [TABLE_ENTRIES:0][AWD-1:0] rom_t;

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      r[i] = tia_pkg::table_atan(i, TABLE_ENTRIES);
    end
    return r;
  endfunction

  localparam rom_t ANGLE_ROM = build_rom();

  // stage 1: index scaling and end-of-table clamp
  logic [PW-1:0]  scaled;
  logic [AW-1:0]  idx;
  logic           clamp;
  logic           s1_valid_r;
  logic [AW-1:0]  s1_a0_r;
  logic [AW-1:0]  s1_a1_r;
  logic [FB-1:0]  s1_frac_r;
  tia_pkg::tia_tag_t s1_tag_r;

  assign scaled = PW'(in_ratio) * PW'(TABLE_ENTRIES);
  assign idx    = scaled[PW-1:FB];
  assign clamp  = (idx >= AW'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (clamp) begin
      s1_a0_r   <= AW'(TABLE_ENTRIES);
      s1_a1_r   <= AW'(TABLE_ENTRIES);
      s1_frac_r <= '0;
    end else begin
      s1_a0_r   <= idx;
      s1_a1_r   <= idx + 1'b1;
      s1_frac_r <= scaled[FB-1:0];
    end
    s1_tag_r <= in_tag;
  end

  // stage 2: rom read of both neighbors
  logic                 s2_valid_r;
  logic [AWD-1:0]       s2_t0_r;
  logic [AWD-1:0]       s2_t1_r;
  logic [FB-1:0]        s2_frac_r;
  tia_pkg::tia_tag_t    s2_tag_r;

  always_ff @(posedge clk) begin
    s2_t0_r   <= ANGLE_ROM[s1_a0_r];
    s2_t1_r   <= ANGLE_ROM[s1_a1_r];
    s2_frac_r <= s1_frac_r;
    s2_tag_r  <= s1_tag_r;
  end

  // stage 3: slope magnitude and sign
  logic signed [AWD:0]  slope;
  logic                 s3_valid_r;
  logic                 s3_neg_r;
  logic [AWD-1:0]       s3_abs_r;
  logic [AWD-1:0]       s3_t0_r;
  logic [FB-1:0]        s3_frac_r;
  tia_pkg::tia_tag_t    s3_tag_r;

  assign slope = $signed({s2_t1_r[AWD-1], s2_t1_r}) - $signed({s2_t0_r[AWD-1], s2_t0_r});

  always_ff @(posedge clk) begin
    s3_neg_r  <= slope[AWD];
    s3_abs_r  <= slope[AWD] ? AWD'(-slope) : AWD'(slope);
    s3_t0_r   <= s2_t0_r;
    s3_frac_r <= s2_frac_r;
    s3_tag_r  <= s2_tag_r;
  end

  // stage 4: fraction times slope
  logic                 s4_valid_r;
  logic                 s4_neg_r;
  logic [FB+AWD-1:0]    s4_prod_r;
  logic [AWD-1:0]       s4_t0_r;
  tia_pkg::tia_tag_t    s4_tag_r;

  always_ff @(posedge clk) begin
    s4_prod_r <= (FB+AWD)'(s3_frac_r) * (FB+AWD)'(s3_abs_r);
    s4_neg_r  <= s3_neg_r;
    s4_t0_r   <= s3_t0_r;
    s4_tag_r  <= s3_tag_r;
  end

  // stage 5: round half away from zero and apply
  logic [FB+AWD:0]      rounded;
  logic [AWD-1:0]       step;
  logic                 s5_valid_r;
  logic [AWD-1:0]       s5_oct_r;
  tia_pkg::tia_tag_t    s5_tag_r;

  assign rounded = {1'b0, s4_prod_r} + (FB+AWD+1)'(1 << (FB - 1));
  assign step    = rounded[FB+AWD-1:FB];

  always_ff @(posedge clk) begin
    s5_oct_r <= s4_neg_r ? (s4_t0_r - step) : (s4_t0_r + step);
    s5_tag_r <= s4_tag_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  assign out_valid = s5_valid_r;
  assign out_oct   = $signed(s5_oct_r);
  assign out_tag   = s5_tag_r;

  // neighbors are adjacent, or both the last entry with no fraction
  a_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((s1_a1_r == s1_a0_r + 1'b1) ||
                    ((s1_a0_r == AW'(TABLE_ENTRIES)) && (s1_a1_r == s1_a0_r) &&
                     (s1_frac_r == '0))))
    else $error("tia_interp: bad table neighbors");

  // first-octant angle stays within zero to pi/4
  a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_valid_r && !s5_tag_r.special) |->
      ((s5_oct_r[AWD-1] == 1'b0) && ($signed(s5_oct_r) <= tia_pkg::ANG_QUARTER_PI)))
    else $error("tia_interp: octant angle out of range");

endmodule

FILE: src/table_interp_atan2.sv
// ----------------------------------------------------------------------------
// table_interp_atan2
// Four-quadrant arctangent: folds (x, y) into the first octant, divides,
// interpolates in an atan table and maps the angle back by quadrant.
// ----------------------------------------------------------------------------
// pipeline: 24 register stages from request to out_valid, the first loaded at the
//   accepting edge (1 fold, 17 divider, 5 table, 1 quadrant)
// throughput: one request per cycle while busy is low, fully pipelined; the receiver cannot stall
// reset: synchronous, clears all valid bits; busy is high during reset and
//   in the cycle after it, then stays low
module table_interp_atan2 #(
  parameter int TABLE_ENTRIES = tia_pkg::DEF_TABLE_ENTRIES,
  parameter int SAMPLE_WIDTH  = tia_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_x_coord,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_y_coord,
  output logic                                 out_valid,
  output logic signed [tia_pkg::ANGLE_W-1:0]   out_angle
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int AWD = tia_pkg::ANGLE_W;

  // busy only while coming out of reset
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // fold: magnitudes, octant choice and special cases
  logic [W-1:0]        mag_x;
  logic [W-1:0]        mag_y;
  logic                x_zero;
  logic                y_zero;
  logic                x_gt;
  tia_pkg::tia_tag_t   tag_nxt;

  assign mag_x  = in_x_coord[W-1] ? W'(~in_x_coord + 1'b1) : W'(in_x_coord);
  assign mag_y  = in_y_coord[W-1] ? W'(~in_y_coord + 1'b1) : W'(in_y_coord);
  assign x_zero = (in_x_coord == '0);
  assign y_zero = (in_y_coord == '0);
  assign x_gt   = (mag_x > mag_y);

  always_comb begin
    tag_nxt.special = x_zero || y_zero;
    tag_nxt.swap    = !x_gt;
    tag_nxt.x_pos   = !in_x_coord[W-1] && !x_zero;
    tag_nxt.y_pos   = !in_y_coord[W-1] && !y_zero;
    if (y_zero) begin
      tag_nxt.spec_angle = tag_nxt.x_pos ? '0 : tia_pkg::ANG_PI;
    end else begin
      tag_nxt.spec_angle = tag_nxt.y_pos ? tia_pkg::ANG_HALF_PI : -tia_pkg::ANG_HALF_PI;
    end
  end

  logic                f_valid_r;
  logic [W-1:0]        f_small_r;
  logic [W-1:0]        f_large_r;
  tia_pkg::tia_tag_t   f_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    f_small_r <= x_gt ? mag_y : mag_x;
    f_large_r <= x_gt ? mag_x : mag_y;
    f_tag_r   <= tag_nxt;
  end

  // ratio of the smaller to the larger magnitude
  logic                               d_valid;
  logic [tia_pkg::RATIO_W-1:0]        d_ratio;
  tia_pkg::tia_tag_t                  d_tag;

  tia_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid_r),
    .in_small  (f_small_r),
    .in_large  (f_large_r),
    .in_tag    (f_tag_r),
    .out_valid (d_valid),
    .out_ratio (d_ratio),
    .out_tag   (d_tag)
  );

  // table lookup and interpolation
  logic                        i_valid;
  logic signed [AWD-1:0]       i_oct;
  tia_pkg::tia_tag_t           i_tag;

  tia_interp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ratio  (d_ratio),
    .in_tag    (d_tag),
    .out_valid (i_valid),
    .out_oct   (i_oct),
    .out_tag   (i_tag)
  );

  // quadrant mapping
  logic signed [AWD-1:0] oct_angle;
  logic signed [AWD-1:0] angle_nxt;
  logic                  out_valid_r;
  logic signed [AWD-1:0] out_angle_r;

  assign oct_angle = i_tag.swap ? (tia_pkg::ANG_HALF_PI - i_oct) : i_oct;

  always_comb begin
    if (i_tag.special) begin
      angle_nxt = i_tag.spec_angle;
    end else if (i_tag.x_pos) begin
      angle_nxt = i_tag.y_pos ? oct_angle : -oct_angle;
    end else begin
      angle_nxt = i_tag.y_pos ? (tia_pkg::ANG_PI - oct_angle) : (oct_angle - tia_pkg::ANG_PI);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r <= angle_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

  // every delivered angle lies within minus pi to pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_angle <= tia_pkg::ANG_PI) && (out_angle >= -tia_pkg::ANG_PI)))
    else $error("table_interp_atan2: angle out of range");

endmodule

FILE: verif/table_interp_atan2_checker.sv
// ----------------------------------------------------------------------------
// table_interp_atan2_checker
// Watches the request and result channels of the atan2 block, predicts the
// angle of every accepted (x, y) request and compares each result strobe with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module table_interp_atan2_checker #(
  parameter int TABLE_ENTRIES = tia_pkg::DEF_TABLE_ENTRIES,
  parameter int SAMPLE_WIDTH  = tia_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_x_coord,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_y_coord,
  input  logic                               out_valid,
  input  logic signed [tia_pkg::ANGLE_W-1:0] out_angle,
  output int                                 err_cnt,
  output int                                 pending_cnt,
  output int                                 checked_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROT_STEPS = 30;

  // cordic rotation angles, q2.30
  localparam longint ROT_ANGLE [ROT_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0]     x;
    logic signed [SAMPLE_WIDTH-1:0]     y;
    logic signed [tia_pkg::ANGLE_W-1:0] angle;
  } angle_req_t;

  int         atan_lut [0:TABLE_ENTRIES];
  angle_req_t expected_angles [$];
  angle_req_t head;
  int         n_err     = 0;
  int         n_checked = 0;

  // atan(num/den) in q3.13 via vectoring cordic, rounded half up
  function automatic int lut_entry(input int num, input int den);
    longint cx;
    longint cy;
    longint z;
    longint sx;
    longint sy;
    int     k;
    if (num == 0) return 0;
    cx = longint'(den) <<< 30;
    cy = longint'(num) <<< 30;
    z  = 0;
    for (k = 0; k < ROT_STEPS; k++) begin
      sx = cx >>> k;
      sy = cy >>> k;
      if (cy > 0) begin
        cx = cx + sy;
        cy = cy - sx;
        z  = z + ROT_ANGLE[k];
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        z  = z - ROT_ANGLE[k];
      end
    end
    if (z < 0) z = 0;
    return int'((z + 64'sd65536) >>> 17);
  endfunction

  // first-octant angle of num/den, 0 < num <= den, interpolated in the table
  function automatic longint octant_interp(input longint num, input longint den);
    longint ratio;
    longint scaled;
    longint idx;
    longint frac;
    longint t0;
    longint d;
    ratio  = (num <<< 16) / den;
    scaled = ratio * TABLE_ENTRIES;
    idx    = scaled >>> 16;
    frac   = scaled & 64'hFFFF;
    // ratio of one lands on the last entry
    if (idx >= TABLE_ENTRIES) return longint'(atan_lut[TABLE_ENTRIES]);
    t0 = atan_lut[idx];
    d  = longint'(atan_lut[idx + 1]) - t0;
    if (d >= 0) return t0 + ((frac * d + 32768) >>> 16);
    return t0 - ((frac * (-d) + 32768) >>> 16);
  endfunction

  // full-circle angle of one request
  function automatic logic signed [tia_pkg::ANGLE_W-1:0] predict_angle(
    input logic signed [SAMPLE_WIDTH-1:0] x,
    input logic signed [SAMPLE_WIDTH-1:0] y
  );
    longint xs;
    longint ys;
    longint ax;
    longint ay;
    longint g;
    longint res;
    xs = x;
    ys = y;
    if (ys == 0) begin
      // both zero falls here too and gives pi
      res = (xs > 0) ? 0 : longint'(tia_pkg::ANG_PI);
    end else if (xs == 0) begin
      res = (ys > 0) ? longint'(tia_pkg::ANG_HALF_PI) : -longint'(tia_pkg::ANG_HALF_PI);
    end else begin
      ax = (xs < 0) ? -xs : xs;
      ay = (ys < 0) ? -ys : ys;
      if (ax > ay) g = octant_interp(ay, ax);
      else g = longint'(tia_pkg::ANG_HALF_PI) - octant_interp(ax, ay);
      if (xs > 0) res = (ys > 0) ? g : -g;
      else res = (ys > 0) ? (longint'(tia_pkg::ANG_PI) - g) : (g - longint'(tia_pkg::ANG_PI));
    end
    return tia_pkg::ANGLE_W'(res);
  endfunction

  // table contents, built at the start of simulation
  initial begin : build_lut
    int i;
    for (i = 0; i <= TABLE_ENTRIES; i++) atan_lut[i] = lut_entry(i, TABLE_ENTRIES);
  end

  // compare result strobes, then queue the prediction of an accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_angles.delete();
      n_err       = 0;
      n_checked   = 0;
      err_cnt     <= 0;
      pending_cnt <= 0;
      checked_cnt <= 0;
    end else begin
      if (out_valid) begin
        if (expected_angles.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result with no request outstanding: angle %0d",
                                    out_angle);
        end else begin
          head = expected_angles.pop_front();
          n_checked++;
          if (out_angle !== head.angle) begin
            n_err++;
            if (n_err <= 10) $display("angle mismatch x=%0d y=%0d: expected %0d, got %0d",
                                      head.x, head.y, head.angle, out_angle);
          end
        end
      end
      if (start && !busy) begin
        head.x     = in_x_coord;
        head.y     = in_y_coord;
        head.angle = predict_angle(in_x_coord, in_y_coord);
        expected_angles.push_back(head);
      end
      err_cnt     <= n_err;
      pending_cnt <= expected_angles.size();
      checked_cnt <= n_checked;
    end
  end

endmodule

FILE: verif/table_interp_atan2_tb.sv
// ----------------------------------------------------------------------------
// table_interp_atan2_tb
// Drives directed and random (x, y) requests into the atan2 block with random
// gaps and idle-free bursts; the checker beside the block predicts and
// compares every angle, and this top gives the verdict.
// ----------------------------------------------------------------------------
module table_interp_atan2_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TE        = tia_pkg::DEF_TABLE_ENTRIES;
  localparam int SW        = tia_pkg::DEF_SAMPLE_WIDTH;
  localparam int N_RANDOM  = 1700;
  localparam int CYC_LIMIT = 250000;
  localparam int DRAIN_CYC = 40;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic signed [SW-1:0]               in_x_coord;
  logic signed [SW-1:0]               in_y_coord;
  logic                               out_valid;
  logic signed [tia_pkg::ANGLE_W-1:0] out_angle;

  int err_cnt;
  int pending_cnt;
  int checked_cnt;
  int n_sent     = 0;
  int n_directed = 0;
  int cycle_cnt  = 0;
  bit no_idle    = 0;

  table_interp_atan2 #(
    .TABLE_ENTRIES(TE),
    .SAMPLE_WIDTH (SW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .out_valid (out_valid),
    .out_angle (out_angle)
  );

  table_interp_atan2_checker #(
    .TABLE_ENTRIES(TE),
    .SAMPLE_WIDTH (SW)
  ) angle_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .out_valid  (out_valid),
    .out_angle  (out_angle),
    .err_cnt    (err_cnt),
    .pending_cnt(pending_cnt),
    .checked_cnt(checked_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // idle cycles before the next request, none inside a burst
  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  // one request, called at a rising edge, returns at the accepting edge
  task automatic send_coord(input logic signed [SW-1:0] x, input logic signed [SW-1:0] y);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  // extreme value of one coordinate
  function automatic logic signed [SW-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  // random request drawn from a mix of shapes
  task automatic gen_coord(output logic signed [SW-1:0] x, output logic signed [SW-1:0] y);
    logic signed [SW-1:0] m;
    logic signed [SW-1:0] t;
    int                   mode;
    mode = $urandom_range(0, 15);
    x    = SW'($urandom);
    y    = SW'($urandom);
    case (mode)
      // small magnitudes, zeros on either axis come up often
      6, 7: begin
        x = SW'($urandom_range(0, 16) - 8);
        y = SW'($urandom_range(0, 16) - 8);
      end
      8: y = '0;
      9: x = '0;
      // equal magnitudes, random signs
      10, 11: begin
        m = SW'($urandom);
        x = $urandom_range(0, 1) ? m : -m;
        y = $urandom_range(0, 1) ? m : -m;
      end
      // just off the diagonal
      12, 13: begin
        y = x + SW'($urandom_range(0, 6)) - SW'(3);
        if ($urandom_range(0, 1)) y = -y;
      end
      14: begin
        x = pick_extreme();
        y = pick_extreme();
      end
      // one coordinate tiny against a large one
      15: begin
        y = SW'($urandom_range(1, 4));
        if ($urandom_range(0, 1)) y = -y;
        if ($urandom_range(0, 1)) begin
          t = x;
          x = y;
          y = t;
        end
      end
      default: ;
    endcase
  endtask

  // stimulus
  initial begin : stim
    logic signed [SW-1:0] rx;
    logic signed [SW-1:0] ry;
    int                   i;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: axes, both zero, equal magnitudes, most negative values
    send_coord(16'sd0, 16'sd0);
    send_coord(16'sd1, 16'sd0);
    send_coord(-16'sd1, 16'sd0);
    send_coord(16'sd32767, 16'sd0);
    send_coord(-16'sd32768, 16'sd0);
    send_coord(16'sd0, 16'sd1);
    send_coord(16'sd0, -16'sd1);
    send_coord(16'sd0, 16'sd32767);
    send_coord(16'sd0, -16'sd32768);
    send_coord(16'sd32767, 16'sd32767);
    send_coord(-16'sd32768, -16'sd32768);
    send_coord(-16'sd32768, 16'sd32767);
    send_coord(16'sd32767, -16'sd32768);
    send_coord(16'sd1, 16'sd1);
    send_coord(-16'sd1, 16'sd1);
    send_coord(16'sd1, -16'sd1);
    send_coord(-16'sd1, -16'sd1);
    send_coord(-16'sd32768, 16'sd1);
    send_coord(16'sd1, -16'sd32768);
    send_coord(16'sd100, 16'sd99);
    send_coord(16'sd99, 16'sd100);
    send_coord(-16'sd5, 16'sd3);
    send_coord(16'sd3, -16'sd5);
    send_coord(16'sd32767, 16'sd1);
    send_coord(16'sd21845, -16'sd10923);
    n_directed = n_sent;

    // random requests, with idle-free bursts now and then
    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // hold off once until the pipeline has drained
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
      end
      gen_coord(rx, ry);
      send_coord(rx, ry);
    end

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("sent %0d requests (%0d directed, rest random over axes, diagonals, extremes)",
             n_sent, n_directed);
    $display("checked %0d angles, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
